### design/gzhp_pkg.sv
// gzhp_pkg: shared types, codes and helpers for the gzip header parser.
// No dependencies; imported by gzhp_step, gzip_header_parser and gzhp_checker.
`timescale 1ns / 1ps

package gzhp_pkg;

  localparam int unsigned LengthBitsDef = 20;

  localparam logic [7:0] Magic0      = 8'h1f;
  localparam logic [7:0] Magic1      = 8'h8b;
  localparam logic [7:0] MethodDefl  = 8'h08;
  localparam logic [7:0] ReservedMsk = 8'hE0;
  localparam logic [4:0] FlagExtra   = 5'h04;
  localparam logic [4:0] FlagName    = 5'h08;
  localparam logic [4:0] FlagComment = 5'h10;
  localparam logic [4:0] FlagHcrc    = 5'h02;

  // indices of the fixed-header bytes: magic, method, flags, time and the last one
  localparam logic [3:0] IdxMagic0 = 4'd0;
  localparam logic [3:0] IdxMagic1 = 4'd1;
  localparam logic [3:0] IdxMethod = 4'd2;
  localparam logic [3:0] IdxFlags  = 4'd3;
  localparam logic [3:0] IdxTime0  = 4'd4;
  localparam logic [3:0] IdxTime3  = 4'd7;
  localparam logic [3:0] IdxLast   = 4'd9;

  typedef enum logic [3:0] {
    PhFixed   = 4'd0,
    PhXlo     = 4'd1,
    PhXhi     = 4'd2,
    PhXskip   = 4'd3,
    PhName    = 4'd4,
    PhComment = 4'd5,
    PhCrc0    = 4'd6,
    PhCrc1    = 4'd7,
    PhIdle    = 4'd8
  } phase_e;

  typedef enum logic [2:0] {
    SecExtra   = 3'd0,
    SecName    = 3'd1,
    SecComment = 3'd2,
    SecCrc     = 3'd3,
    SecEnd     = 3'd4
  } sec_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StMagic    = 3'd1,
    StMethod   = 3'd2,
    StReserved = 3'd3,
    StTrunc    = 3'd4
  } status_e;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  fixed_index;
    logic [4:0]  flags;
    logic [31:0] time_store;
    logic [7:0]  extra_low;
    logic [15:0] extra_left;
  } parse_state_t;

  typedef struct packed {
    logic        valid;
    status_e     status;
    logic [31:0] mod_time;
    logic [4:0]  flag_bits;
  } parse_res_t;

  localparam parse_state_t StateReset = '{
    phase:       PhFixed,
    fixed_index: 4'd0,
    flags:       5'd0,
    time_store:  32'd0,
    extra_low:   8'd0,
    extra_left:  16'd0
  };

  // first optional section at or after sec that the flags enable; PhIdle when none
  function automatic phase_e enter_section(sec_e sec, logic [4:0] flags);
    phase_e ph;
    if (sec <= SecExtra && (flags & FlagExtra) != 5'd0) begin
      ph = PhXlo;
    end else if (sec <= SecName && (flags & FlagName) != 5'd0) begin
      ph = PhName;
    end else if (sec <= SecComment && (flags & FlagComment) != 5'd0) begin
      ph = PhComment;
    end else if (sec <= SecCrc && (flags & FlagHcrc) != 5'd0) begin
      ph = PhCrc0;
    end else begin
      ph = PhIdle;
    end
    return ph;
  endfunction

endpackage

### design/gzip_header_parser.sv
// gzip_header_parser: top level, byte stream in, one header summary per file out.
// Depends on gzhp_pkg and gzhp_step.
//
//   channel  dir  handshake                payload
//   in       in   in_valid_i / in_stall_o  data_byte_i, last_byte_i
//   out      out  out_valid_o / out_stall_i status_o, mod_time_o, flag_bits_o,
//                                          header_length_o
//
// One byte per cycle while in_stall_o is low; each byte passes through the step logic
// into the parse state and result registers. A result appears on the cycle after the
// byte that completes the header, shows an error, or marks end of file.
// Reset puts the parser at the first magic byte with an empty result register.
// in_stall_o rises only while a result is held and out_stall_i is high.
`timescale 1ns / 1ps

module gzip_header_parser import gzhp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [2:0]             status_o,
  output logic [31:0]            mod_time_o,
  output logic [4:0]             flag_bits_o,
  output logic [LENGTH_BITS-1:0] header_length_o
);

  parse_state_t           state_q, state_d;
  logic [LENGTH_BITS-1:0] length_q, length_d;
  parse_res_t             res;
  logic                   accept;
  logic                   out_valid_q, out_valid_d;
  status_e                status_q;
  logic [31:0]            time_q;
  logic [4:0]             flags_q;
  logic [LENGTH_BITS-1:0] hlen_q;

  gzhp_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .state_i     (state_q),
    .length_i    (length_q),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .state_o     (state_d),
    .length_o    (length_d),
    .res_o       (res)
  );

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept && res.valid) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateReset;
      length_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q  <= state_d;
        length_q <= length_d;
      end
    end
  end

  // result payload; header length is the count after this byte
  always_ff @(posedge clk_i) begin
    if (accept && res.valid) begin
      status_q <= res.status;
      time_q   <= res.mod_time;
      flags_q  <= res.flag_bits;
      hlen_q   <= (length_q != {LENGTH_BITS{1'b1}} && state_q.phase != PhIdle)
                  ? length_q + LENGTH_BITS'(1) : length_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign mod_time_o      = time_q;
  assign flag_bits_o     = flags_q;
  assign header_length_o = hlen_q;

endmodule

### design/gzhp_step.sv
// gzhp_step: next-state and result logic for one header byte.
// Depends on gzhp_pkg.
`timescale 1ns / 1ps

module gzhp_step import gzhp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input  parse_state_t           state_i,
  input  logic [LENGTH_BITS-1:0] length_i,
  input  logic [7:0]             data_byte_i,
  input  logic                   last_byte_i,
  output parse_state_t           state_o,
  output logic [LENGTH_BITS-1:0] length_o,
  output parse_res_t             res_o
);

  parse_state_t           st;
  logic [LENGTH_BITS-1:0] len;
  logic [15:0]            xlen;
  status_e                err;
  logic                   done;

  always_comb begin
    st   = state_i;
    len  = length_i;
    err  = StOk;
    done = 1'b0;
    xlen = {data_byte_i, state_i.extra_low};

    if (state_i.phase != PhIdle && length_i != {LENGTH_BITS{1'b1}}) begin
      len = length_i + LENGTH_BITS'(1);
    end

    case (state_i.phase)
      PhFixed: begin
        if (state_i.fixed_index == IdxMagic0 && data_byte_i != Magic0) begin
          err = StMagic;
        end else if (state_i.fixed_index == IdxMagic1 && data_byte_i != Magic1) begin
          err = StMagic;
        end else if (state_i.fixed_index == IdxMethod && data_byte_i != MethodDefl) begin
          err = StMethod;
        end else if (state_i.fixed_index == IdxFlags) begin
          if ((data_byte_i & ReservedMsk) != 8'd0) begin
            err = StReserved;
          end else begin
            st.flags = data_byte_i[4:0];
          end
        end else if (state_i.fixed_index >= IdxTime0 && state_i.fixed_index <= IdxTime3) begin
          st.time_store = {data_byte_i, state_i.time_store[31:8]};
        end
        if (err == StOk) begin
          if (state_i.fixed_index >= IdxLast) begin
            st.phase = enter_section(SecExtra, st.flags);
            done     = (st.phase == PhIdle);
          end else begin
            st.fixed_index = state_i.fixed_index + 4'd1;
          end
        end
      end
      PhXlo: begin
        st.extra_low = data_byte_i;
        st.phase     = PhXhi;
      end
      PhXhi: begin
        st.extra_left = xlen;
        if (xlen == 16'd0) begin
          st.phase = enter_section(SecName, state_i.flags);
          done     = (st.phase == PhIdle);
        end else begin
          st.phase = PhXskip;
        end
      end
      PhXskip: begin
        st.extra_left = state_i.extra_left - 16'd1;
        if (st.extra_left == 16'd0) begin
          st.phase = enter_section(SecName, state_i.flags);
          done     = (st.phase == PhIdle);
        end
      end
      PhName: begin
        if (data_byte_i == 8'd0) begin
          st.phase = enter_section(SecComment, state_i.flags);
          done     = (st.phase == PhIdle);
        end
      end
      PhComment: begin
        if (data_byte_i == 8'd0) begin
          st.phase = enter_section(SecCrc, state_i.flags);
          done     = (st.phase == PhIdle);
        end
      end
      PhCrc0: begin
        st.phase = PhCrc1;
      end
      PhCrc1: begin
        st.phase = enter_section(SecEnd, state_i.flags);
        done     = (st.phase == PhIdle);
      end
      default: begin
        st.phase = PhIdle;
      end
    endcase

    res_o = '{valid: 1'b0, status: StOk, mod_time: 32'd0, flag_bits: 5'd0};
    if (err != StOk) begin
      st.phase = PhIdle;
      res_o    = '{valid: 1'b1, status: err, mod_time: 32'd0, flag_bits: 5'd0};
    end else if (done) begin
      res_o = '{valid: 1'b1, status: StOk, mod_time: st.time_store, flag_bits: st.flags};
    end

    length_o = len;
    if (last_byte_i) begin
      if (!res_o.valid && st.phase != PhIdle) begin
        res_o = '{valid: 1'b1, status: StTrunc, mod_time: 32'd0, flag_bits: 5'd0};
      end
      st       = StateReset;
      length_o = '0;
    end
    state_o = st;
  end

endmodule

### design/gzhp_checker.sv
// gzhp_checker: port-level assertions for gzip_header_parser, bound to the top.
// Depends on gzhp_pkg and gzip_header_parser.
`timescale 1ns / 1ps

module gzhp_checker import gzhp_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_stall_o,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input logic [2:0]             status_o,
  input logic [31:0]            mod_time_o,
  input logic [4:0]             flag_bits_o,
  input logic [LENGTH_BITS-1:0] header_length_o
);

  // a stalled result holds until transferred
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(mod_time_o) && $stable(flag_bits_o) && $stable(header_length_o))
    else $error("result changed while stalled");

  // input side backs up only behind a held, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a blocked result");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == StOk || status_o == StMagic || status_o == StMethod
      || status_o == StReserved || status_o == StTrunc)
    else $error("status code out of range");

  a_err_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> mod_time_o == 32'd0 && flag_bits_o == 5'd0)
    else $error("error result carries header fields");

  // a complete header is at least the ten fixed bytes
  a_ok_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StOk |-> header_length_o >= LENGTH_BITS'(10))
    else $error("ok header shorter than fixed part");

endmodule

bind gzip_header_parser gzhp_checker #(.LENGTH_BITS(LENGTH_BITS)) u_gzhp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .status_o        (status_o),
  .mod_time_o      (mod_time_o),
  .flag_bits_o     (flag_bits_o),
  .header_length_o (header_length_o)
);
